// ----- hdl/ldf_pkg.sv -----
// ----------------------------------------------------------------------------
// ldf_pkg: shared types and constants of the light distance falloff core
// Widths of the fixed-point formats, light kinds and the structs that ride
// alongside the square root and divider pipelines.
// ----------------------------------------------------------------------------
package ldf_pkg;

  localparam int KIND_W      = 3;
  localparam int OFS_W       = 24;
  localparam int RADIUS_W    = 23;
  localparam int COEF_W      = 24;
  localparam int SQ_W        = 47;
  localparam int R2_W        = 46;
  localparam int D2_W        = 48;
  localparam int FRAC_W      = 16;
  localparam int RADICAND_W  = D2_W + FRAC_W;
  localparam int ROOT_W      = 32;
  localparam int REM_W       = 34;
  localparam int SQ_STAGES   = ROOT_W;
  localparam int LCD_W       = COEF_W + ROOT_W;
  localparam int HALF_W      = D2_W / 2;
  localparam int QPART_W     = COEF_W + HALF_W;
  localparam int QPROD_W     = COEF_W + D2_W;
  localparam int QTERM_W     = 51;
  localparam int DEN_W       = 57;
  localparam int DIVR_W      = 49;
  localparam int DREM_W      = DIVR_W - 1;
  localparam int RATIO_W     = 32;
  localparam int DIV_STAGES  = RATIO_W;

  localparam logic [QTERM_W-1:0]  QTERM_CAP     = QTERM_W'(1) << 50;
  localparam logic [RATIO_W-1:0]  FX_ONE        = RATIO_W'(65536);
  localparam logic [RATIO_W-1:0]  RATIO_MAX     = '1;
  localparam logic [DEN_W-1:0]    DEN_SAT_MAX   = DEN_W'(65536);
  localparam logic [DEN_W-1:0]    DEN_DIV_MAX   = DEN_W'(1) << 48;
  localparam logic [D2_W-1:0]     SURF_DIV_MAX  = D2_W'(1) << 32;
  localparam logic [DREM_W-1:0]   DIV_INIT_REM  = DREM_W'(65536);

  typedef enum logic [KIND_W-1:0] {
    KIND_SURFACE = 3'd0,
    KIND_SKY     = 3'd1,
    KIND_QUAKE   = 3'd2,
    KIND_SKY_AMB = 3'd3,
    KIND_POINT   = 3'd4,
    KIND_SPOT    = 3'd5
  } light_kind_t;

  // Data that travels beside the square root pipeline.
  typedef struct packed {
    light_kind_t        kind;
    logic [D2_W-1:0]    d2;
    logic               culled;
    logic [COEF_W-1:0]  cc;
    logic [COEF_W-1:0]  lc;
    logic [COEF_W-1:0]  qc;
  } sq_side_t;

  // Data that travels beside the divider pipeline.
  typedef struct packed {
    logic               divide;
    logic [RATIO_W-1:0] ratio;
    logic               sat;
  } div_side_t;

endpackage

// ----- hdl/ldf_front.sv -----
// ----------------------------------------------------------------------------
// ldf_front: squared distance and cull test
// Three stages: offset magnitudes, squares, then the sum and radius compare.
// ----------------------------------------------------------------------------
module ldf_front import ldf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [KIND_W-1:0]   light_kind,
  input  logic [OFS_W-1:0]    offset_x,
  input  logic [OFS_W-1:0]    offset_y,
  input  logic [OFS_W-1:0]    offset_z,
  input  logic [RADIUS_W-1:0] cull_radius,
  input  logic [COEF_W-1:0]   constant_coef,
  input  logic [COEF_W-1:0]   linear_coef,
  input  logic [COEF_W-1:0]   quadratic_coef,
  output logic                out_valid,
  output sq_side_t            out_side
);

  logic                v1, v2;
  light_kind_t         kind1, kind2;
  logic [OFS_W-1:0]    mx, my, mz;
  logic [RADIUS_W-1:0] rad1;
  logic                rnz1, rnz2;
  logic [COEF_W-1:0]   cc1, lc1, qc1, cc2, lc2, qc2;
  logic [SQ_W-1:0]     sqx, sqy, sqz;
  logic [R2_W-1:0]     r2;
  logic [2*OFS_W-1:0]  px, py, pz;
  logic [D2_W-1:0]     d2_sum;

  assign px = mx * mx;
  assign py = my * my;
  assign pz = mz * mz;
  assign d2_sum = D2_W'(sqx) + D2_W'(sqy) + D2_W'(sqz);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    // Two's complement magnitude; the most negative value maps to 2^23.
    mx    <= offset_x[OFS_W-1] ? (~offset_x + OFS_W'(1)) : offset_x;
    my    <= offset_y[OFS_W-1] ? (~offset_y + OFS_W'(1)) : offset_y;
    mz    <= offset_z[OFS_W-1] ? (~offset_z + OFS_W'(1)) : offset_z;
    kind1 <= light_kind_t'(light_kind);
    rad1  <= cull_radius;
    rnz1  <= |cull_radius;
    cc1   <= constant_coef;
    lc1   <= linear_coef;
    qc1   <= quadratic_coef;

    sqx   <= px[SQ_W-1:0];
    sqy   <= py[SQ_W-1:0];
    sqz   <= pz[SQ_W-1:0];
    r2    <= R2_W'(rad1) * R2_W'(rad1);
    kind2 <= kind1;
    rnz2  <= rnz1;
    cc2   <= cc1;
    lc2   <= lc1;
    qc2   <= qc1;

    out_side.kind   <= kind2;
    out_side.d2     <= d2_sum;
    out_side.culled <= rnz2 && (d2_sum > D2_W'(r2));
    out_side.cc     <= cc2;
    out_side.lc     <= lc2;
    out_side.qc     <= qc2;
  end

endmodule

// ----- hdl/ldf_sqrt.sv -----
// ----------------------------------------------------------------------------
// ldf_sqrt: pipelined integer square root
// One result bit per stage: floor(sqrt(d2 * 2^16)) over 32 stages.
// ----------------------------------------------------------------------------
module ldf_sqrt import ldf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sq_side_t          in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output sq_side_t          out_side
);

  logic                  vld   [SQ_STAGES];
  sq_side_t              side  [SQ_STAGES];
  logic [ROOT_W-1:0]     root_q[SQ_STAGES];
  logic [REM_W-1:0]      rem_q [SQ_STAGES-1];
  logic [RADICAND_W-1:0] rad_q [SQ_STAGES-1];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic                  v_in;
    sq_side_t              side_in;
    logic [ROOT_W-1:0]     root_in;
    logic [REM_W-1:0]      rem_in;
    logic [RADICAND_W-1:0] rad_in;
    logic [REM_W+1:0]      rem_sh, trial, diff;
    logic                  take;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign side_in = in_side;
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = {in_side.d2, FRAC_W'(0)};
    end else begin : g_rest
      assign v_in    = vld[k-1];
      assign side_in = side[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_in, rad_in[RADICAND_W-1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign take   = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
      side[k]   <= side_in;
      root_q[k] <= {root_in[ROOT_W-2:0], take};
    end

    if (k < SQ_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[k] <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        rad_q[k] <= rad_in << 2;
      end
    end
  end

  assign out_valid = vld[SQ_STAGES-1];
  assign root      = root_q[SQ_STAGES-1];
  assign out_side  = side[SQ_STAGES-1];

endmodule

// ----- hdl/ldf_den.sv -----
// ----------------------------------------------------------------------------
// ldf_den: attenuation denominator and result selection
// Four stages: products, quadratic clamp, denominator sum, then the choice
// between a direct result and a division for each light kind.
// ----------------------------------------------------------------------------
module ldf_den import ldf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] root,
  input  sq_side_t          in_side,
  output logic              out_valid,
  output logic [DIVR_W-1:0] divisor,
  output div_side_t         out_side
);

  logic               v1, v2, v3;
  sq_side_t           s1, s2, s3;
  logic [ROOT_W-1:0]  root1, root2;
  logic [LCD_W-1:0]   lcd_c, lcd1, lcd2;
  logic [QPART_W-1:0] qlo_c, qhi_c, qlo1, qhi1;
  logic [QPROD_W-1:0] qprod_c;
  logic [QTERM_W-1:0] qterm2;
  logic [DEN_W-1:0]   den3;
  logic [RATIO_W-1:0] quake3;
  logic [ROOT_W-1:0]  lc_wide;
  logic               divide_next;
  logic [RATIO_W-1:0] ratio_next;
  logic               sat_next;
  logic [DIVR_W-1:0]  divisor_next;

  assign lcd_c   = in_side.lc * root;
  assign qlo_c   = in_side.qc * in_side.d2[HALF_W-1:0];
  assign qhi_c   = in_side.qc * in_side.d2[D2_W-1:HALF_W];
  assign qprod_c = {qhi1, HALF_W'(0)} + QPROD_W'(qlo1);
  assign lc_wide = ROOT_W'(s2.lc);

  always_comb begin
    divide_next  = 1'b0;
    ratio_next   = FX_ONE;
    sat_next     = 1'b0;
    divisor_next = den3[DIVR_W-1:0];
    unique case (s3.kind)
      KIND_SURFACE: begin
        divisor_next = {s3.d2[DIVR_W-FRAC_W-1:0], FRAC_W'(0)};
        if (s3.culled || s3.d2 > SURF_DIV_MAX) begin
          ratio_next = '0;
        end else if (s3.d2 >= D2_W'(FX_ONE)) begin
          divide_next = 1'b1;
        end
      end
      KIND_QUAKE: begin
        ratio_next = quake3;
      end
      KIND_POINT, KIND_SPOT: begin
        if (s3.culled || den3 > DEN_DIV_MAX) begin
          ratio_next = '0;
        end else if (den3 <= DEN_SAT_MAX) begin
          ratio_next = RATIO_MAX;
          sat_next   = 1'b1;
        end else begin
          divide_next = 1'b1;
        end
      end
      default: begin
        ratio_next = FX_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
    s1    <= in_side;
    root1 <= root;
    lcd1  <= lcd_c;
    qlo1  <= qlo_c;
    qhi1  <= qhi_c;

    s2    <= s1;
    root2 <= root1;
    lcd2  <= lcd1;
    qterm2 <= (qprod_c > QPROD_W'(QTERM_CAP)) ? QTERM_CAP : qprod_c[QTERM_W-1:0];

    s3     <= s2;
    den3   <= DEN_W'({s2.cc, FRAC_W'(0)}) + DEN_W'(lcd2) + DEN_W'(qterm2);
    quake3 <= (lc_wide > root2) ? RATIO_W'(lc_wide - root2) : '0;

    out_side.divide <= divide_next;
    out_side.ratio  <= ratio_next;
    out_side.sat    <= sat_next;
    divisor         <= divisor_next;
  end

endmodule

// ----- hdl/ldf_div.sv -----
// ----------------------------------------------------------------------------
// ldf_div: pipelined restoring divider for 2^48 / divisor
// One quotient bit per stage over 32 stages; the divisor exceeds 2^16, so the
// quotient fits 32 bits and the partial remainder starts at 2^16.
// ----------------------------------------------------------------------------
module ldf_div import ldf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [DIVR_W-1:0]  divisor,
  input  div_side_t          in_side,
  output logic               out_valid,
  output logic [RATIO_W-1:0] quotient,
  output div_side_t          out_side
);

  logic               vld  [DIV_STAGES];
  div_side_t          side [DIV_STAGES];
  logic [RATIO_W-1:0] quo_q[DIV_STAGES];
  logic [DREM_W-1:0]  rem_q[DIV_STAGES-1];
  logic [DIVR_W-1:0]  dvs_q[DIV_STAGES-1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic               v_in;
    div_side_t          side_in;
    logic [RATIO_W-1:0] quo_in;
    logic [DREM_W-1:0]  rem_in;
    logic [DIVR_W-1:0]  dvs_in;
    logic [DIVR_W-1:0]  rem_sh, diff;
    logic               take;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign side_in = in_side;
      assign quo_in  = '0;
      assign rem_in  = DIV_INIT_REM;
      assign dvs_in  = divisor;
    end else begin : g_rest
      assign v_in    = vld[k-1];
      assign side_in = side[k-1];
      assign quo_in  = quo_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign dvs_in  = dvs_q[k-1];
    end

    assign rem_sh = {rem_in, 1'b0};
    assign take   = rem_sh >= dvs_in;
    assign diff   = rem_sh - dvs_in;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
      side[k]  <= side_in;
      quo_q[k] <= {quo_in[RATIO_W-2:0], take};
    end

    if (k < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[k] <= take ? diff[DREM_W-1:0] : rem_sh[DREM_W-1:0];
        dvs_q[k] <= dvs_in;
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quotient  = quo_q[DIV_STAGES-1];
  assign out_side  = side[DIV_STAGES-1];

endmodule

// ----- hdl/light_distance_falloff_core.sv -----
// ----------------------------------------------------------------------------
// light_distance_falloff_core: distance falloff ratio of one light at a point
// Computes the Q16.16 intensity ratio for every light kind (sky kinds give
// 1.0) from the light-to-point offset, the cull radius and the coefficients.
// ----------------------------------------------------------------------------
// Usage: drive the light fields and pulse start. A transaction is accepted at
// the rising edge where start is high and busy is low. busy is high only
// while rst is asserted, so a new transaction can be accepted in every cycle.
// Each accepted transaction produces exactly one result, and done is high
// for one cycle with ratio and saturated valid in that cycle.
// Results leave in the order the transactions arrived. The receiver cannot
// stall, so nothing is buffered at the output; throughput is one result per
// clock. The latency is set by the 32-stage square root, the 32-stage
// divider, three front stages, four denominator stages and the output
// register. A synchronous reset clears every valid bit in the pipeline, which
// drops all transactions in flight; no result appears for them.
// ----------------------------------------------------------------------------
module light_distance_falloff_core import ldf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   light_kind,
  input  logic [OFS_W-1:0]    offset_x,
  input  logic [OFS_W-1:0]    offset_y,
  input  logic [OFS_W-1:0]    offset_z,
  input  logic [RADIUS_W-1:0] cull_radius,
  input  logic [COEF_W-1:0]   constant_coef,
  input  logic [COEF_W-1:0]   linear_coef,
  input  logic [COEF_W-1:0]   quadratic_coef,
  output logic                done,
  output logic [RATIO_W-1:0]  ratio,
  output logic                saturated
);

  logic               accept;
  logic               fr_valid, sq_valid, dn_valid, dv_valid;
  sq_side_t           fr_side, sq_side;
  logic [ROOT_W-1:0]  sq_root;
  logic [DIVR_W-1:0]  dn_divisor;
  div_side_t          dn_side, dv_side;
  logic [RATIO_W-1:0] dv_quotient;

  // The pipeline never holds off input; only reset blocks new transactions.
  assign busy   = rst;
  assign accept = start && !busy;

  // Offset magnitudes, squared distance and the cull test.
  ldf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (accept),
    .light_kind     (light_kind),
    .offset_x       (offset_x),
    .offset_y       (offset_y),
    .offset_z       (offset_z),
    .cull_radius    (cull_radius),
    .constant_coef  (constant_coef),
    .linear_coef    (linear_coef),
    .quadratic_coef (quadratic_coef),
    .out_valid      (fr_valid),
    .out_side       (fr_side)
  );

  // Distance in Q.16 as the floor of the square root of d2 * 2^16.
  ldf_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // Denominator forming and per-kind selection. Results that need no
  // division (sky, quake, culled, saturated, out of range) are decided
  // here and ride through the divider as sideband data.
  ldf_den u_den (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .root      (sq_root),
    .in_side   (sq_side),
    .out_valid (dn_valid),
    .divisor   (dn_divisor),
    .out_side  (dn_side)
  );

  // Quotient 2^48 / divisor. Surface lights use d2 * 2^16 as the divisor,
  // which gives the same floor as 2^32 / d2.
  ldf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dn_valid),
    .divisor   (dn_divisor),
    .in_side   (dn_side),
    .out_valid (dv_valid),
    .quotient  (dv_quotient),
    .out_side  (dv_side)
  );

  // Output register: pick the quotient or the direct result.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    ratio     <= dv_side.divide ? dv_quotient : dv_side.ratio;
    saturated <= dv_side.divide ? 1'b0 : dv_side.sat;
  end

endmodule
